// ----- rtl/x86enc_pkg.sv -----
// Shared types, codes and helpers for the x86-64 instruction encoder.
// No dependencies.
`timescale 1ns / 1ps
package x86enc_pkg;

  localparam int MaxBytes = 16;

  typedef enum logic [4:0] {
    ACT_ALU = 5'd0, ACT_ALUI = 5'd1, ACT_SHIFT = 5'd2, ACT_UNARY = 5'd3,
    ACT_MOVI = 5'd4, ACT_IMULR = 5'd5, ACT_IMULI = 5'd6, ACT_MOVZX = 5'd7,
    ACT_MOVSX = 5'd8, ACT_PUSH = 5'd9, ACT_POP = 5'd10, ACT_RET = 5'd11,
    ACT_JCC = 5'd12, ACT_SETCC = 5'd13, ACT_JMP = 5'd14, ACT_CALL = 5'd15,
    ACT_JMPI = 5'd16, ACT_CALLI = 5'd17
  } action_t;

  // Decoded request, fields named by their roles in the byte layout.
  typedef struct packed {
    logic       err;
    logic       empty;
    logic       has_66;
    logic       has_rex;
    logic [7:0] rex;
    logic [1:0] n_op;      // opcode bytes
    logic [7:0] op0;
    logic [7:0] op1;
    logic       has_mrm;
    logic [2:0] mrm_reg;
    logic [3:0] base;
    logic       mem;
    logic [31:0] disp;
    logic [3:0] n_imm;     // immediate bytes, 0..8
    logic [63:0] imm;
  } dec_t;

  // Assembled instruction: up to 16 bytes, with a count.
  typedef struct packed {
    logic                 err;
    logic [4:0]           len;
    logic [MaxBytes*8-1:0] bytes;
  } frame_t;

  function automatic logic fit8(input logic [63:0] v);
    return (v[63:7] == '0) || (v[63:7] == '1);
  endfunction
  function automatic logic fit16(input logic [63:0] v);
    return (v[63:15] == '0) || (v[63:15] == '1);
  endfunction
  function automatic logic fit32(input logic [63:0] v);
    return (v[63:31] == '0) || (v[63:31] == '1);
  endfunction

endpackage

// ----- rtl/x86enc_decode.sv -----
// Stage one: decodes a request into prefix, opcode, ModRM and immediate fields.
// Depends on x86enc_pkg.
`timescale 1ns / 1ps
module x86enc_decode (
  input  logic [4:0]  action,
  input  logic [3:0]  sub_op,
  input  logic [1:0]  width_code,
  input  logic [1:0]  src_wc,
  input  logic [3:0]  reg_operand,
  input  logic [3:0]  rm_base,
  input  logic        rm_in_memory,
  input  logic        rm_is_source,
  input  logic [31:0] displacement,
  input  logic [63:0] immediate,
  output x86enc_pkg::dec_t dec
);
  import x86enc_pkg::*;

  logic       w8, w16, w64, wide;
  logic [3:0] rr, rmr, dr, sr;
  logic       f8, f16, f32, sm, dm;
  logic [3:0] isz;  // shortest signed size in bytes: 1, 2, 4, 8
  logic [3:0] wbytes;

  always_comb begin
    w8  = (width_code == 2'd0);
    w16 = (width_code == 2'd1);
    w64 = (width_code == 2'd3);
    wide = !w8;
    f8  = fit8(immediate);
    f16 = fit16(immediate);
    f32 = fit32(immediate);
    isz = f8 ? 4'd1 : (f16 ? 4'd2 : (f32 ? 4'd4 : 4'd8));
    wbytes = 4'd1 << width_code;
    rr = 4'd0;
    rmr = rm_base;
    dr = 4'd0; sr = 4'd0; sm = 1'b0; dm = 1'b0;
    dec = '0;
    dec.base = rm_base;
    dec.mem = rm_in_memory;
    dec.disp = displacement;
    dec.imm = immediate;
    dec.has_mrm = 1'b1;
    dec.n_op = 2'd1;
    dec.has_66 = w16;
    case (action)
      ACT_ALU: begin
        if (rm_is_source) begin
          dr = reg_operand; sr = rm_base; sm = rm_in_memory;
        end else begin
          dr = rm_base; dm = rm_in_memory; sr = reg_operand;
        end
        if (sub_op == 4'd8 && !dm) begin
          // test is symmetric: when the destination is a register, the form swaps roles
          dm = sm; sm = 1'b0;
          {dr, sr} = {sr, dr};
        end
        rmr = sm ? sr : dr;
        rr  = sm ? dr : sr;
        dec.base = rmr;
        dec.mrm_reg = rr[2:0];
        if (sub_op == 4'd9) begin
          dec.op0 = 8'h88 + {7'd0, wide} + (sm ? 8'd2 : 8'd0);
          if (!rm_in_memory && dr == sr) dec.empty = 1'b1;
        end else if (sub_op == 4'd8) begin
          dec.op0 = 8'h84 + {7'd0, wide} + (sm ? 8'd2 : 8'd0);
        end else if (sub_op < 4'd8) begin
          dec.op0 = {2'b00, sub_op[2:0], 3'd0} + {7'd0, wide} + (sm ? 8'd2 : 8'd0);
        end else dec.err = 1'b1;
      end
      ACT_ALUI: begin
        dec.mrm_reg = (sub_op == 4'd8) ? 3'd0 : sub_op[2:0];
        if (sub_op > 4'd8 || !f32) dec.err = 1'b1;
        else if (sub_op == 4'd8) begin
          if (isz > wbytes) dec.err = 1'b1;
          dec.op0 = wide ? 8'hF7 : 8'hF6;
          dec.n_imm = w64 ? 4'd4 : wbytes;
        end else if (sub_op <= 4'd1 && immediate == '0) dec.empty = 1'b1;
        else begin
          if (isz > wbytes) dec.err = 1'b1;
          if (w8) begin dec.op0 = 8'h80; dec.n_imm = 4'd1; end
          else if (f8) begin dec.op0 = 8'h83; dec.n_imm = 4'd1; end
          else begin dec.op0 = 8'h81; dec.n_imm = w16 ? 4'd2 : 4'd4; end
        end
      end
      ACT_SHIFT: begin
        dec.mrm_reg = sub_op[2:0];
        if (sub_op == 4'd6 || sub_op > 4'd7 || immediate[63:6] != '0
            || {1'b0, immediate[5:0]} >= (7'd8 << width_code)) dec.err = 1'b1;
        else if (immediate == '0) dec.empty = 1'b1;
        dec.op0 = ((immediate == 64'd1) ? 8'hD0 : 8'hC0) + {7'd0, wide};
        dec.n_imm = (immediate == 64'd1) ? 4'd0 : 4'd1;
      end
      ACT_UNARY: begin
        dec.mrm_reg = sub_op[2:0];
        if (sub_op < 4'd2 || sub_op > 4'd7) dec.err = 1'b1;
        dec.op0 = 8'hF6 + {7'd0, wide};
      end
      ACT_MOVI: begin
        if (immediate == '0 && !rm_in_memory) begin
          rr = rm_base;
          dec.mrm_reg = rm_base[2:0];
          dec.op0 = 8'h30 + {7'd0, wide};
        end else begin
          if (isz > wbytes) dec.err = 1'b1;
          dec.n_imm = wbytes;
          if (rm_in_memory && w64) begin
            if (!f32) dec.err = 1'b1;
            dec.n_imm = 4'd4;
          end
          if (!rm_in_memory) begin
            dec.has_mrm = 1'b0;
            dec.op0 = (w8 ? 8'hB0 : 8'hB8) + {5'd0, rm_base[2:0]};
          end else dec.op0 = w8 ? 8'hC6 : 8'hC7;
        end
      end
      ACT_IMULR, ACT_IMULI: begin
        rr = reg_operand;
        dec.mrm_reg = reg_operand[2:0];
        if (w8) dec.err = 1'b1;
        if (action == ACT_IMULR) begin
          dec.n_op = 2'd2; dec.op0 = 8'h0F; dec.op1 = 8'hAF;
        end else begin
          if (!f32 || isz > wbytes) dec.err = 1'b1;
          dec.op0 = f8 ? 8'h6B : 8'h69;
          dec.n_imm = f8 ? 4'd1 : (w16 ? 4'd2 : 4'd4);
        end
      end
      ACT_MOVZX, ACT_MOVSX: begin
        rr = reg_operand;
        dec.mrm_reg = reg_operand[2:0];
        if (src_wc == 2'd3 || width_code <= src_wc) dec.err = 1'b1;
        if (action == ACT_MOVZX && src_wc == 2'd2) begin
          dec.has_66 = 1'b0;
          if (rm_in_memory) dec.op0 = 8'h8B;
          else begin
            // Register form is a store-direction mov: source in the reg field.
            dec.op0 = 8'h89;
            rr = rm_base;
            rmr = reg_operand;
            dec.mrm_reg = rm_base[2:0];
            dec.base = reg_operand;
            if (reg_operand == rm_base) dec.empty = 1'b1;
          end
        end else if (src_wc == 2'd2) dec.op0 = 8'h63;
        else begin
          dec.n_op = 2'd2; dec.op0 = 8'h0F;
          dec.op1 = ((action == ACT_MOVZX) ? 8'hB6 : 8'hBE) + {7'd0, src_wc[0]};
        end
      end
      ACT_PUSH, ACT_POP: begin
        dec.has_66 = 1'b0; dec.has_mrm = 1'b0;
        dec.op0 = ((action == ACT_PUSH) ? 8'h50 : 8'h58) + {5'd0, reg_operand[2:0]};
      end
      ACT_RET: begin
        dec.has_66 = 1'b0; dec.has_mrm = 1'b0; dec.op0 = 8'hC3;
      end
      ACT_JCC, ACT_JMP, ACT_CALL: begin
        dec.has_66 = 1'b0; dec.has_mrm = 1'b0;
        if (!f32) dec.err = 1'b1;
        if (action == ACT_CALL) begin
          dec.op0 = 8'hE8; dec.n_imm = 4'd4;
        end else if (f8) begin
          dec.op0 = (action == ACT_JCC) ? (8'h70 + {4'd0, sub_op}) : 8'hEB;
          dec.n_imm = 4'd1;
        end else begin
          dec.n_imm = 4'd4;
          if (action == ACT_JCC) begin
            dec.n_op = 2'd2; dec.op0 = 8'h0F; dec.op1 = 8'h80 + {4'd0, sub_op};
          end else dec.op0 = 8'hE9;
        end
      end
      ACT_SETCC: begin
        dec.has_66 = 1'b0;
        dec.n_op = 2'd2; dec.op0 = 8'h0F; dec.op1 = 8'h90 + {4'd0, sub_op};
      end
      ACT_JMPI, ACT_CALLI: begin
        dec.has_66 = 1'b0;
        dec.mrm_reg = (action == ACT_JMPI) ? 3'd4 : 3'd2;
        dec.op0 = 8'hFF;
      end
      default: dec.err = 1'b1;
    endcase
    // REX prefix
    case (action)
      ACT_PUSH, ACT_POP: begin
        dec.has_rex = reg_operand[3];
        dec.rex = 8'h41;
      end
      ACT_RET, ACT_JCC, ACT_JMP, ACT_CALL: dec.has_rex = 1'b0;
      ACT_SETCC: begin
        dec.has_rex = 1'b1; dec.rex = {7'b0100000, rm_base[3]};
      end
      ACT_JMPI, ACT_CALLI: begin
        dec.has_rex = rm_base[3]; dec.rex = {7'b0100000, rm_base[3]};
      end
      ACT_MOVZX: begin
        if (src_wc == 2'd2) begin
          dec.has_rex = rr[3] || rmr[3];
          dec.rex = {5'b01000, rr[3], 1'b0, rmr[3]};
        end else begin
          dec.has_rex = w8 || w64 || rr[3] || rmr[3];
          dec.rex = {4'b0100, w64, rr[3], 1'b0, rmr[3]};
        end
      end
      default: begin
        dec.has_rex = w8 || w64 || rr[3] || rmr[3];
        dec.rex = {4'b0100, w64, rr[3], 1'b0, rmr[3]};
      end
    endcase
  end
endmodule

// ----- rtl/x86enc_assemble.sv -----
// Stage two: places prefix, opcode, ModRM, SIB, displacement and immediate bytes.
// Depends on x86enc_pkg.
`timescale 1ns / 1ps
module x86enc_assemble (
  input  x86enc_pkg::dec_t   dec,
  output x86enc_pkg::frame_t frame
);
  import x86enc_pkg::*;

  logic [1:0] mode;
  logic [4:0] pos;
  logic [7:0] b [MaxBytes];
  logic [63:0] disp_x;

  always_comb begin
    disp_x = {{32{dec.disp[31]}}, dec.disp};
    if (!dec.mem) mode = 2'd3;
    else if (dec.disp == '0 && dec.base[2:0] != 3'd5) mode = 2'd0;
    else if (fit8(disp_x)) mode = 2'd1;
    else mode = 2'd2;
    for (int i = 0; i < MaxBytes; i++) b[i] = 8'h00;
    pos = 5'd0;
    if (dec.has_66) begin b[pos[3:0]] = 8'h66; pos = pos + 5'd1; end
    if (dec.has_rex) begin b[pos[3:0]] = dec.rex; pos = pos + 5'd1; end
    b[pos[3:0]] = dec.op0; pos = pos + 5'd1;
    if (dec.n_op == 2'd2) begin b[pos[3:0]] = dec.op1; pos = pos + 5'd1; end
    if (dec.has_mrm) begin
      b[pos[3:0]] = {mode, dec.mrm_reg, dec.base[2:0]}; pos = pos + 5'd1;
      if (mode != 2'd3 && dec.base[2:0] == 3'd4) begin
        b[pos[3:0]] = 8'h24; pos = pos + 5'd1;
      end
      if (mode == 2'd1) begin b[pos[3:0]] = dec.disp[7:0]; pos = pos + 5'd1; end
      if (mode == 2'd2) begin
        for (int k = 0; k < 4; k++) b[(pos[3:0] + 4'(k))] = dec.disp[8*k +: 8];
        pos = pos + 5'd4;
      end
    end
    for (int k = 0; k < 8; k++)
      if (4'(k) < dec.n_imm) b[(pos[3:0] + 4'(k))] = dec.imm[8*k +: 8];
    pos = pos + {1'b0, dec.n_imm};
    for (int i = 0; i < MaxBytes; i++) frame.bytes[8*i +: 8] = b[i];
    frame.err = dec.err;
    frame.len = dec.err ? 5'd1 : (dec.empty ? 5'd0 : pos);
  end
endmodule

// ----- rtl/x86enc_serializer.sv -----
// Stage three: holds one assembled instruction and emits it a byte per cycle while out_tready is high.
// Depends on x86enc_pkg.
`timescale 1ns / 1ps
module x86enc_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               frm_valid,
  output logic               frm_ready,
  input  x86enc_pkg::frame_t frm,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);
  import x86enc_pkg::*;

  frame_t     cur_r, cur_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       last_now;

  assign last_now  = (idx_r + 5'd1 == cur_r.len);
  assign out_tvalid = busy_r;
  assign out_tdata  = cur_r.err ? 8'h00 : cur_r.bytes[8*idx_r[3:0] +: 8];
  assign out_tlast  = last_now;
  assign out_tuser  = {1'b0, cur_r.err};
  assign frm_ready  = !busy_r || (out_tready && last_now);

  always_comb begin
    cur_nxt = cur_r; idx_nxt = idx_r; busy_nxt = busy_r;
    if (busy_r && out_tready) begin
      idx_nxt = idx_r + 5'd1;
      if (last_now) busy_nxt = 1'b0;
    end
    if (frm_valid && frm_ready) begin
      cur_nxt = frm; idx_nxt = 5'd0; busy_nxt = (frm.len != 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else busy_r <= busy_nxt;
  end

  a_len_ok: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < cur_r.len)) else $error("byte index beyond length");
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cur_r.err) |-> last_now) else $error("error result not single");
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && out_tready && !last_now) |=> (busy_r && idx_r == $past(idx_r) + 5'd1))
    else $error("byte index did not advance");
endmodule

// ----- rtl/x86_64_instruction_encoder.sv -----
// Top level of the x86-64 instruction encoder.
// Depends on x86enc_pkg, x86enc_decode, x86enc_assemble, x86enc_serializer.
`timescale 1ns / 1ps
// Usage:
//   A request enters on the in_ channel (in_tvalid/in_tready) and describes one
//   instruction. The out_ channel returns its machine code one byte a transfer,
//   with out_tlast on the final byte. An illegal request yields a single
//   transfer with out_tuser[0] (encode_error) set, a zero byte and out_tlast.
//   Forms that change nothing (for example mov of a register to itself)
//   produce no output at all.
// Pipeline: request register, decode register, assemble register, then the
//   byte serializer, which registers each frame before its first byte goes out.
// Throughput: one output byte per cycle while out_tready is high; the
//   serializer's byte counter steps through each instruction's bytes.
//   A new request enters while earlier ones are in flight.
// Reset: rst_n low clears all valid bits; no output is pending afterwards.
// Stall: when out_tready is low the current byte holds, the stages fill and
//   in_tready drops only once every stage holds an item; nothing is lost.
module x86_64_instruction_encoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata, lowest bit up: action[4:0], sub_op[8:5], width_code[10:9],
  // source_width_code[12:11], reg_operand[16:13], rm_base[20:17],
  // rm_in_memory[21], rm_is_source[22], displacement[54:23],
  // immediate[118:55], zero fill [119].
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: code_byte[7:0].
  output logic [7:0]   out_tdata,
  // tuser: encode_error[0], zero fill [1].
  output logic [1:0]   out_tuser,
  // tlast: last_byte.
  output logic         out_tlast
);
  import x86enc_pkg::*;

  logic [119:0] req_r, req_nxt;
  logic         v0_r, v0_nxt, v1_r, v1_nxt, v2_r, v2_nxt;
  dec_t         dec_w, dec_r, dec_nxt;
  frame_t       frm_w, frm_r, frm_nxt;
  logic         frm_ready, adv2, adv1, adv0;

  // Each stage moves when its successor is free or moves too.
  assign adv2 = !v2_r || frm_ready;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;
  assign in_tready = adv0;

  x86enc_decode u_dec (
    .action(req_r[4:0]), .sub_op(req_r[8:5]), .width_code(req_r[10:9]),
    .src_wc(req_r[12:11]), .reg_operand(req_r[16:13]), .rm_base(req_r[20:17]),
    .rm_in_memory(req_r[21]), .rm_is_source(req_r[22]),
    .displacement(req_r[54:23]), .immediate(req_r[118:55]), .dec(dec_w)
  );

  x86enc_assemble u_asm (.dec(dec_r), .frame(frm_w));

  always_comb begin
    req_nxt = req_r; v0_nxt = v0_r;
    dec_nxt = dec_r; v1_nxt = v1_r;
    frm_nxt = frm_r; v2_nxt = v2_r;
    if (adv0) begin req_nxt = in_tdata; v0_nxt = in_tvalid; end
    if (adv1) begin dec_nxt = dec_w; v1_nxt = v0_r; end
    if (adv2) begin frm_nxt = frm_w; v2_nxt = v1_r; end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    dec_r <= dec_nxt;
    frm_r <= frm_nxt;
    if (!rst_n) begin
      v0_r <= 1'b0; v1_r <= 1'b0; v2_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt; v1_r <= v1_nxt; v2_r <= v2_nxt;
    end
  end

  x86enc_serializer u_ser (
    .clk(clk), .rst_n(rst_n), .frm_valid(v2_r), .frm_ready(frm_ready),
    .frm(frm_r), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !frm_ready) |=> (v2_r && $stable(frm_r))) else $error("stage lost");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v0_r && v1_r && v2_r)) else $error("stall with empty stage");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (frm_r.len <= 5'd16)) else $error("frame too long");
endmodule
